@@ hdl/gmms_pkg.sv @@
package gmms_pkg;

  localparam int CFG_W  = 12;
  localparam int CFG_AW = 3;
  localparam int IDX_W  = 11;

  localparam logic [CFG_AW-1:0] CFG_MODULE_SIZE  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_FINDER_ROW   = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_FINDER_COL   = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_IMAGE_WIDTH  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_IMAGE_HEIGHT = 3'd4;

  localparam logic [6:0]  MODULE_SIZE_RST  = 7'd8;
  localparam logic [11:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [11:0] IMAGE_HEIGHT_RST = 12'd480;

  typedef struct packed {
    logic hit;
    logic first;
    logic last;
  } cell_flags_t;

endpackage

@@ hdl/gmms_ram.sv @@
module gmms_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/gmms_div.sv @@
module gmms_div #(
  parameter int N = 11,
  parameter int D = 7,
  localparam int SW = $clog2(N + 1)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [N-1:0] quot,
  output logic [D-1:0] rem
);

  logic [SW-1:0] step;
  logic [N-1:0]  dvd;
  logic [D-1:0]  dsr;
  logic [D:0]    trial;
  logic [D:0]    diff;
  logic          ge;
  logic [D-1:0]  rem_next;

  assign trial    = {rem, dvd[N-1]};
  assign ge       = trial >= {1'b0, dsr};
  assign diff     = trial - {1'b0, dsr};
  assign rem_next = ge ? diff[D-1:0] : trial[D-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + SW'(1);
        if (step == SW'(N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dsr  <= divisor;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      dvd  <= dvd << 1;
      rem  <= rem_next;
      quot <= {quot[N-2:0], ge};
    end
  end

endmodule

@@ hdl/gmms_locate.sv @@
module gmms_locate #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_MODULE = 64,
  localparam int POS_W = ($clog2(MAX_WIDTH) > 11) ? $clog2(MAX_WIDTH) : 11,
  localparam int DIM_W = POS_W + 1,
  localparam int SZ_W = $clog2(MAX_MODULE + 1),
  localparam int IC_W = $clog2(MAX_MODULE),
  localparam int SUB_W = (SZ_W + 3 > 12) ? SZ_W + 3 : 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [gmms_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [gmms_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        advance,
  input  logic                        frame_start,
  output logic                        busy,
  output logic [SZ_W-1:0]             sz,
  output gmms_pkg::cell_flags_t       flags,
  output logic [POS_W-1:0]            cell_row,
  output logic [POS_W-1:0]            cell_col
);

  logic [6:0]  module_size;
  logic [10:0] finder_row;
  logic [10:0] finder_col;
  logic [11:0] image_width;
  logic [11:0] image_height;

  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic [POS_W-1:0] sr;
  logic [POS_W-1:0] sc;

  logic [POS_W-1:0] row_pos;
  logic [POS_W-1:0] col_pos;
  logic [IC_W-1:0]  row_in_cell;
  logic [IC_W-1:0]  col_in_cell;
  logic [POS_W-1:0] cell_row_index;
  logic [POS_W-1:0] cell_col_index;
  logic             recalc_req;

  logic [POS_W-1:0] r_e, c_e, kr_e, kc_e;
  logic [IC_W-1:0]  ir_e, ic_e;
  logic [DIM_W-1:0] row_end, col_end, row_inc, col_inc;
  logic             col_wrap, ic_wrap, ir_wrap;

  logic [POS_W-1:0] row_pos_next, col_pos_next, cell_row_index_next, cell_col_index_next;
  logic [IC_W-1:0]  row_in_cell_next, col_in_cell_next;

  logic [POS_W-1:0] row_dvd, col_dvd, row_quot, col_quot;
  logic [SZ_W-1:0]  row_rem, col_rem;
  logic             row_busy, col_busy, row_done, col_done;

  function automatic logic [POS_W-1:0] grid_start(input logic [10:0] finder,
                                                  input logic [SZ_W-1:0] s);
    logic [SUB_W-1:0] twice;
    logic [SUB_W-1:0] back;
    logic [SUB_W-1:0] span;
    twice = SUB_W'({finder, 1'b0});
    back  = (SUB_W'(s) << 2) + SUB_W'(s);
    span  = (twice - back) >> 1;
    return (twice < back) ? '0 : POS_W'(span);
  endfunction

  always_comb begin
    if (module_size == '0) begin
      sz = SZ_W'(1);
    end else if (int'(module_size) > MAX_MODULE) begin
      sz = SZ_W'(MAX_MODULE);
    end else begin
      sz = SZ_W'(module_size);
    end
    if (image_width == '0) begin
      w = DIM_W'(1);
    end else if (DIM_W'(image_width) > DIM_W'(MAX_WIDTH)) begin
      w = DIM_W'(MAX_WIDTH);
    end else begin
      w = DIM_W'(image_width);
    end
    if (image_height == '0) begin
      h = DIM_W'(1);
    end else if (DIM_W'(image_height) > DIM_W'(MAX_WIDTH)) begin
      h = DIM_W'(MAX_WIDTH);
    end else begin
      h = DIM_W'(image_height);
    end
  end

  assign sr = grid_start(finder_row, sz);
  assign sc = grid_start(finder_col, sz);

  assign r_e  = frame_start ? '0 : row_pos;
  assign c_e  = frame_start ? '0 : col_pos;
  assign ir_e = frame_start ? '0 : row_in_cell;
  assign ic_e = frame_start ? '0 : col_in_cell;
  assign kr_e = frame_start ? '0 : cell_row_index;
  assign kc_e = frame_start ? '0 : cell_col_index;

  assign row_end = DIM_W'(r_e) - DIM_W'(ir_e) + DIM_W'(sz);
  assign col_end = DIM_W'(c_e) - DIM_W'(ic_e) + DIM_W'(sz);

  assign flags.hit   = (r_e >= sr) && (c_e >= sc) && (row_end < h) && (col_end < w);
  assign flags.first = (ir_e == '0) && (ic_e == '0);
  assign flags.last  = (SZ_W'(ir_e) == sz - SZ_W'(1)) && (SZ_W'(ic_e) == sz - SZ_W'(1));
  assign cell_row    = kr_e;
  assign cell_col    = kc_e;

  assign col_inc  = DIM_W'(c_e) + DIM_W'(1);
  assign row_inc  = DIM_W'(r_e) + DIM_W'(1);
  assign col_wrap = col_inc >= w;
  assign ic_wrap  = SZ_W'(ic_e) + SZ_W'(1) == sz;
  assign ir_wrap  = SZ_W'(ir_e) + SZ_W'(1) == sz;

  always_comb begin
    col_pos_next = col_wrap ? '0 : col_inc[POS_W-1:0];
    row_pos_next = r_e;
    if (col_wrap) begin
      row_pos_next = (row_inc >= h) ? '0 : row_inc[POS_W-1:0];
    end

    if (col_pos_next == sc) begin
      col_in_cell_next    = '0;
      cell_col_index_next = '0;
    end else if (ic_wrap) begin
      col_in_cell_next    = '0;
      cell_col_index_next = kc_e + POS_W'(1);
    end else begin
      col_in_cell_next    = ic_e + IC_W'(1);
      cell_col_index_next = kc_e;
    end

    row_in_cell_next    = ir_e;
    cell_row_index_next = kr_e;
    if (col_wrap) begin
      if (row_pos_next == sr) begin
        row_in_cell_next    = '0;
        cell_row_index_next = '0;
      end else if (ir_wrap) begin
        row_in_cell_next    = '0;
        cell_row_index_next = kr_e + POS_W'(1);
      end else begin
        row_in_cell_next    = ir_e + IC_W'(1);
      end
    end
  end

  assign row_dvd = (row_pos >= sr) ? row_pos - sr : '0;
  assign col_dvd = (col_pos >= sc) ? col_pos - sc : '0;

  gmms_div #(.N(POS_W), .D(SZ_W)) u_row_div (
    .clk      (clk),
    .rst      (rst),
    .start    (recalc_req),
    .dividend (row_dvd),
    .divisor  (sz),
    .busy     (row_busy),
    .done     (row_done),
    .quot     (row_quot),
    .rem      (row_rem)
  );

  gmms_div #(.N(POS_W), .D(SZ_W)) u_col_div (
    .clk      (clk),
    .rst      (rst),
    .start    (recalc_req),
    .dividend (col_dvd),
    .divisor  (sz),
    .busy     (col_busy),
    .done     (col_done),
    .quot     (col_quot),
    .rem      (col_rem)
  );

  assign busy = recalc_req | row_busy | col_busy | row_done | col_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      module_size    <= gmms_pkg::MODULE_SIZE_RST;
      finder_row     <= '0;
      finder_col     <= '0;
      image_width    <= gmms_pkg::IMAGE_WIDTH_RST;
      image_height   <= gmms_pkg::IMAGE_HEIGHT_RST;
      recalc_req     <= 1'b0;
      row_pos        <= '0;
      col_pos        <= '0;
      row_in_cell    <= '0;
      col_in_cell    <= '0;
      cell_row_index <= '0;
      cell_col_index <= '0;
    end else begin
      recalc_req <= cfg_we;
      if (cfg_we) begin
        case (cfg_addr)
          gmms_pkg::CFG_MODULE_SIZE:  module_size  <= cfg_data[6:0];
          gmms_pkg::CFG_FINDER_ROW:   finder_row   <= cfg_data[10:0];
          gmms_pkg::CFG_FINDER_COL:   finder_col   <= cfg_data[10:0];
          gmms_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
          gmms_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end
      if (advance) begin
        row_pos        <= row_pos_next;
        col_pos        <= col_pos_next;
        row_in_cell    <= row_in_cell_next;
        col_in_cell    <= col_in_cell_next;
        cell_row_index <= cell_row_index_next;
        cell_col_index <= cell_col_index_next;
      end else if (row_done && col_done) begin
        row_in_cell    <= IC_W'(row_rem);
        col_in_cell    <= IC_W'(col_rem);
        cell_row_index <= row_quot;
        cell_col_index <= col_quot;
      end
    end
  end

endmodule

@@ hdl/grid_majority_module_sampler.sv @@
// Samples a binarised raster stream on a grid of square module cells laid
// from the finder centre, one pixel beat per clock while s_tready is high, and
// emits one module bit per cell from the output register once the cell's
// bottom-right pixel has passed the count stage. A one-read, one-write line
// store with a registered read holds white counts per grid column; back-to-back
// pixels of a cell are forwarded around the store, so the sustained rate is one
// pixel per cycle unless s_tready is low. After every configuration write
// s_tready drops while two restoring dividers, one quotient bit per cycle,
// re-derive the cell offsets of the current raster position. The line store
// needs no clearing pass: a cell's first pixel always overwrites its count.
module grid_majority_module_sampler #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_MODULE = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,  // pixel
  input  logic                        s_tuser,  // frame_start
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [23:0]                 m_tdata,  // module_row, module_col, module_white
  input  logic                        cfg_we,
  input  logic [gmms_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [gmms_pkg::CFG_W-1:0]  cfg_data
);

  localparam int POS_W = ($clog2(MAX_WIDTH) > 11) ? $clog2(MAX_WIDTH) : 11;
  localparam int SZ_W  = $clog2(MAX_MODULE + 1);
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CNT_W = $clog2(MAX_MODULE * MAX_MODULE + 1);
  localparam int SQ_W  = 2 * SZ_W;
  localparam int IDX_W = gmms_pkg::IDX_W;

  logic                  busy;
  logic [SZ_W-1:0]       sz;
  gmms_pkg::cell_flags_t flags;
  logic [POS_W-1:0]      cell_row;
  logic [POS_W-1:0]      cell_col;

  logic             accept;
  logic             adv;
  logic [AW-1:0]    rd_addr;
  logic [CNT_W-1:0] rd_data;
  logic [CNT_W-1:0] cnt_base;
  logic [CNT_W-1:0] cnt;
  logic [SQ_W-1:0]  sz_sq;
  logic             majority;

  logic             s1_valid;
  logic             s1_first;
  logic             s1_last;
  logic             s1_white;
  logic [AW-1:0]    s1_addr;
  logic [IDX_W-1:0] s1_row;
  logic [IDX_W-1:0] s1_col;
  logic             s1_fwd;
  logic [CNT_W-1:0] s1_fwd_data;

  logic             out_valid;
  logic [IDX_W-1:0] out_row;
  logic [IDX_W-1:0] out_col;
  logic             out_white;

  gmms_locate #(.MAX_WIDTH(MAX_WIDTH), .MAX_MODULE(MAX_MODULE)) u_locate (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .advance     (accept),
    .frame_start (s_tuser),
    .busy        (busy),
    .sz          (sz),
    .flags       (flags),
    .cell_row    (cell_row),
    .cell_col    (cell_col)
  );

  assign adv      = !(s1_valid && s1_last && out_valid && !m_tready);
  assign s_tready = adv && !busy;
  assign accept   = s_tvalid && s_tready;
  assign rd_addr  = cell_col[AW-1:0];

  gmms_ram #(.WIDTH(CNT_W), .DEPTH(MAX_WIDTH)) u_counts (
    .clk   (clk),
    .we    (s1_valid && adv),
    .waddr (s1_addr),
    .wdata (cnt),
    .re    (accept && flags.hit),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign cnt_base = s1_first ? '0 : (s1_fwd ? s1_fwd_data : rd_data);
  assign cnt      = cnt_base + CNT_W'(s1_white);
  assign sz_sq    = SQ_W'(sz) * SQ_W'(sz);
  assign majority = (SQ_W + 1)'({cnt, 1'b0}) > (SQ_W + 1)'(sz_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept && flags.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first    <= flags.first;
      s1_last     <= flags.last;
      s1_white    <= s_tdata != '0;
      s1_addr     <= rd_addr;
      s1_row      <= cell_row[IDX_W-1:0];
      s1_col      <= cell_col[IDX_W-1:0];
      s1_fwd      <= s1_valid && (s1_addr == rd_addr);
      s1_fwd_data <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && s1_valid && s1_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid && s1_last) begin
      out_row   <= s1_row;
      out_col   <= s1_col;
      out_white <= majority;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_white, out_col, out_row};

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_tready)
    else $error("pixel beat taken right after a configuration write");

  a_first_count: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_first |-> cnt <= CNT_W'(1))
    else $error("first pixel of a cell carried a stale count");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1_addr))
    else $error("count stage lost its beat during an output stall");

endmodule
